### rtl/mwm_pkg.sv
// Shared types, constants and output packing for the mecanum wheel mixer.
`timescale 1ns / 1ps
package mwm_pkg;

   localparam int CMD_IN_W   = 16;
   localparam int OUT_W      = 14;
   localparam int WHEEL_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int PACK_W     = 16;

   localparam logic [WHEEL_W-1:0] DRIVEN_WHEELS        = 4'd4;
   localparam logic [WHEEL_W-1:0] CHASSIS_WHEELS_RESET = 4'd4;
   localparam logic [0:0]         REG_CHASSIS_WHEELS   = 1'b0;
   localparam logic [PACK_W-1:0]  OUT_MAX_MAG          = 16'd8191;
   localparam logic [PACK_W-1:0]  OUT_MIN_MAG          = 16'd8192;
   localparam logic [OUT_W-1:0]   OUT_MAX_CODE         = 14'h1FFF;
   localparam logic [OUT_W-1:0]   OUT_MIN_CODE         = 14'h2000;

   typedef struct packed {
      logic       fault;
      logic       bypass;
      logic [3:0] neg;
   } mwm_ctrl_type;

   // Applies the sign to a magnitude and saturates it to the output width.
   function automatic logic signed [OUT_W-1:0] pack_target(input logic neg,
                                                           input logic [PACK_W-1:0] v);
      logic [PACK_W-1:0] n;
      n = -v;
      if (!neg && v > OUT_MAX_MAG) begin
         return OUT_MAX_CODE;
      end else if (neg && v > OUT_MIN_MAG) begin
         return OUT_MIN_CODE;
      end else if (neg) begin
         return n[OUT_W-1:0];
      end else begin
         return v[OUT_W-1:0];
      end
   endfunction

endpackage

### rtl/mwm_req_if.sv
// Request channel carrying the three motion commands.
`timescale 1ns / 1ps
interface mwm_req_if;
   import mwm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [CMD_IN_W-1:0] forward_cmd;
   logic signed [CMD_IN_W-1:0] strafe_cmd;
   logic signed [CMD_IN_W-1:0] rotate_cmd;

   modport source (output valid, forward_cmd, strafe_cmd, rotate_cmd, input ready);
   modport sink   (input valid, forward_cmd, strafe_cmd, rotate_cmd, output ready);
endinterface

### rtl/mwm_rsp_if.sv
// Result channel carrying the four wheel targets and the layout fault flag.
`timescale 1ns / 1ps
interface mwm_rsp_if;
   import mwm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] front_left;
   logic signed [OUT_W-1:0] front_right;
   logic signed [OUT_W-1:0] back_left;
   logic signed [OUT_W-1:0] back_right;
   logic                    layout_fault;

   modport source (output valid, front_left, front_right, back_left, back_right,
                   layout_fault, input ready);
   modport sink   (input valid, front_left, front_right, back_left, back_right,
                   layout_fault, output ready);
endinterface

### rtl/mwm_csr.sv
// APB-style register holding the wheel count.
`timescale 1ns / 1ps
module mwm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mwm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mwm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mwm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [mwm_pkg::WHEEL_W-1:0]        chassis_wheels
);
   import mwm_pkg::*;

   logic [WHEEL_W-1:0] chassis_wheels_ff;
   logic [WHEEL_W-1:0] chassis_wheels_in;
   logic [0:0]         reg_index;
   logic               write_hit;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign write_hit = psel && penable && pwrite && (reg_index == REG_CHASSIS_WHEELS);
   assign chassis_wheels_in = write_hit ? pwdata[WHEEL_W-1:0] : chassis_wheels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chassis_wheels_ff <= CHASSIS_WHEELS_RESET;
      end else begin
         chassis_wheels_ff <= chassis_wheels_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_CHASSIS_WHEELS) begin
         prdata = CSR_DATA_W'(chassis_wheels_ff);
      end
   end

   assign pready         = 1'b1;
   assign chassis_wheels = chassis_wheels_ff;
endmodule

### rtl/mwm_front.sv
// Front stages: command clamping, wheel sums and the largest magnitude.
`timescale 1ns / 1ps
module mwm_front #(
   parameter int FRAC_BITS = 12
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic signed [mwm_pkg::CMD_IN_W-1:0]        forward_cmd,
   input  logic signed [mwm_pkg::CMD_IN_W-1:0]        strafe_cmd,
   input  logic signed [mwm_pkg::CMD_IN_W-1:0]        rotate_cmd,
   input  logic [mwm_pkg::WHEEL_W-1:0]                wheel_count,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [3:0][FRAC_BITS+1:0]                  out_mag,
   output logic [FRAC_BITS+1:0]                       out_div,
   output mwm_pkg::mwm_ctrl_type                      out_ctrl
);
   import mwm_pkg::*;

   localparam int CMD_W = FRAC_BITS + 2;
   localparam int SUM_W = FRAC_BITS + 3;
   localparam int MAG_W = FRAC_BITS + 2;
   localparam logic signed [CMD_IN_W-1:0] ONE_POS = CMD_IN_W'(1 << FRAC_BITS);
   localparam logic signed [CMD_IN_W-1:0] ONE_NEG = -ONE_POS;
   localparam logic [MAG_W-1:0]           ONE_MAG = MAG_W'(1 << FRAC_BITS);

   function automatic logic signed [CMD_W-1:0] clamp_one(input logic signed [CMD_IN_W-1:0] x);
      logic signed [CMD_IN_W-1:0] c;
      c = x;
      if (x > ONE_POS) begin
         c = ONE_POS;
      end else if (x < ONE_NEG) begin
         c = ONE_NEG;
      end
      return c[CMD_W-1:0];
   endfunction

   // Stage one: clamped commands.
   logic                    valid1_ff;
   logic signed [CMD_W-1:0] f1_ff, s1_ff, r1_ff;
   logic                    fault1_ff;
   // Stage two: target magnitudes and signs.
   logic                    valid2_ff;
   logic [3:0][MAG_W-1:0]   mag2_ff;
   mwm_ctrl_type            ctrl2_ff;
   // Stage three: largest magnitude and bypass decision.
   logic                    valid3_ff;
   logic [3:0][MAG_W-1:0]   mag3_ff;
   logic [MAG_W-1:0]        div3_ff;
   mwm_ctrl_type            ctrl3_ff;

   logic ready1, ready2, ready3;

   logic signed [SUM_W-1:0] fe, se, re;
   logic signed [SUM_W-1:0] t_sum [4];
   logic [3:0][MAG_W-1:0]   mag2_in;
   logic [3:0]              neg2_in;
   logic [SUM_W-1:0]        t_abs [4];
   logic [MAG_W-1:0]        max01, max23, max_in;

   assign ready3   = !valid3_ff || out_ready;
   assign ready2   = !valid2_ff || ready3;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   always_comb begin
      fe = SUM_W'(f1_ff);
      se = SUM_W'(s1_ff);
      re = SUM_W'(r1_ff);
      t_sum[0] = fe + se - re;
      t_sum[1] = fe - se + re;
      t_sum[2] = fe - se - re;
      t_sum[3] = fe + se + re;
      for (int i = 0; i < 4; i++) begin
         neg2_in[i] = t_sum[i][SUM_W-1];
         t_abs[i]   = neg2_in[i] ? -t_sum[i] : t_sum[i];
         mag2_in[i] = t_abs[i][MAG_W-1:0];
      end
   end

   always_comb begin
      max01  = (mag2_ff[0] > mag2_ff[1]) ? mag2_ff[0] : mag2_ff[1];
      max23  = (mag2_ff[2] > mag2_ff[3]) ? mag2_ff[2] : mag2_ff[3];
      max_in = (max01 > max23) ? max01 : max23;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            valid1_ff <= in_valid;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
         if (ready3) begin
            valid3_ff <= valid2_ff;
         end
      end
      if (ready1 && in_valid) begin
         f1_ff     <= clamp_one(forward_cmd);
         s1_ff     <= clamp_one(strafe_cmd);
         r1_ff     <= clamp_one(rotate_cmd);
         fault1_ff <= (wheel_count != DRIVEN_WHEELS);
      end
      if (ready2 && valid1_ff) begin
         mag2_ff         <= mag2_in;
         ctrl2_ff.fault  <= fault1_ff;
         ctrl2_ff.bypass <= 1'b0;
         ctrl2_ff.neg    <= neg2_in;
      end
      if (ready3 && valid2_ff) begin
         mag3_ff         <= mag2_ff;
         div3_ff         <= max_in;
         ctrl3_ff.fault  <= ctrl2_ff.fault;
         ctrl3_ff.neg    <= ctrl2_ff.neg;
         ctrl3_ff.bypass <= (max_in <= ONE_MAG);
      end
   end

   assign out_valid = valid3_ff;
   assign out_mag   = mag3_ff;
   assign out_div   = div3_ff;
   assign out_ctrl  = ctrl3_ff;
endmodule

### rtl/mwm_div_stage.sv
// One restoring division step for all four wheel lanes, with its own register.
`timescale 1ns / 1ps
module mwm_div_stage #(
   parameter int FRAC_BITS = 12,
   parameter int STEP      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [3:0][FRAC_BITS+2:0]     in_rem,
   input  logic [3:0][FRAC_BITS:0]       in_quo,
   input  logic [FRAC_BITS+1:0]          in_div,
   input  mwm_pkg::mwm_ctrl_type         in_ctrl,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [3:0][FRAC_BITS+2:0]     out_rem,
   output logic [3:0][FRAC_BITS:0]       out_quo,
   output logic [FRAC_BITS+1:0]          out_div,
   output mwm_pkg::mwm_ctrl_type         out_ctrl
);
   import mwm_pkg::*;

   localparam int REM_W = FRAC_BITS + 3;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int BIT   = FRAC_BITS - STEP;
   localparam logic [Q_W-1:0] QBIT = Q_W'(1) << BIT;

   logic                  valid_ff;
   logic [3:0][REM_W-1:0] rem_ff, rem_in;
   logic [3:0][Q_W-1:0]   quo_ff, quo_in;
   logic [FRAC_BITS+1:0]  div_ff;
   mwm_ctrl_type          ctrl_ff;
   logic [3:0][REM_W-1:0] shifted;
   logic [REM_W-1:0]      div_ext;
   logic                  ready;

   assign div_ext = REM_W'(in_div);

   // The first step weighs the remainder as it stands; later ones double it.
   generate
      if (STEP == 0) begin : g_first
         assign shifted = in_rem;
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               shifted[i] = {in_rem[i][REM_W-2:0], 1'b0};
            end
         end
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rem_in[i] = in_rem[i];
         quo_in[i] = in_quo[i];
         if (!in_ctrl.bypass) begin
            if (shifted[i] >= div_ext) begin
               rem_in[i] = shifted[i] - div_ext;
               quo_in[i] = in_quo[i] | QBIT;
            end else begin
               rem_in[i] = shifted[i];
            end
         end
      end
   end

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
      if (ready && in_valid) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         div_ff  <= in_div;
         ctrl_ff <= in_ctrl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_ctrl  = ctrl_ff;
endmodule

### rtl/mecanum_wheel_mixer.sv
// Top level of the mecanum wheel mixer: front stages, divider pipeline and result register.
// Path: a request passes the front stages, the divider stages and the result register, in
// that order, before its result is offered.
// Throughput: one request per cycle unless the result is stalled; every stage has its own
// valid bit and register. The divider is restoring, one quotient bit per pipeline stage.
// Reset (synchronous, active high) empties the pipeline and sets the wheel count to 4.
`timescale 1ns / 1ps
module mecanum_wheel_mixer #(
   parameter int FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   mwm_req_if.sink                            req,
   mwm_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mwm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mwm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mwm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import mwm_pkg::*;

   // One divider stage per quotient bit, from the weight of 1.0 down to the
   // least significant fraction bit.
   localparam int STEPS = FRAC_BITS + 1;
   localparam int REM_W = FRAC_BITS + 3;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int MAG_W = FRAC_BITS + 2;

   logic [WHEEL_W-1:0] chassis_wheels;

   mwm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .prdata         (csr_prdata),
      .pready         (csr_pready),
      .chassis_wheels (chassis_wheels)
   );

   // Link k of the chain is the output of the front stages (k = 0) or of
   // divider stage k-1.
   logic [STEPS:0]                  lk_valid;
   logic [STEPS:0]                  lk_ready;
   logic [STEPS:0][3:0][REM_W-1:0]  lk_rem;
   logic [STEPS:0][3:0][Q_W-1:0]    lk_quo;
   logic [STEPS:0][MAG_W-1:0]       lk_div;
   mwm_ctrl_type                    lk_ctrl [STEPS+1];
   logic [3:0][MAG_W-1:0]           front_mag;

   mwm_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .forward_cmd (req.forward_cmd),
      .strafe_cmd  (req.strafe_cmd),
      .rotate_cmd  (req.rotate_cmd),
      .wheel_count (chassis_wheels),
      .out_valid   (lk_valid[0]),
      .out_ready   (lk_ready[0]),
      .out_mag     (front_mag),
      .out_div     (lk_div[0]),
      .out_ctrl    (lk_ctrl[0])
   );

   // The divider starts with the magnitude as its remainder and an empty
   // quotient. When no scaling is needed the stages leave both untouched, so
   // the remainder still holds the unscaled magnitude at the end.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lk_rem[0][i] = REM_W'(front_mag[i]);
         lk_quo[0][i] = '0;
      end
   end

   generate
      for (genvar k = 0; k < STEPS; k++) begin : g_div
         mwm_div_stage #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (k)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (lk_valid[k]),
            .in_ready  (lk_ready[k]),
            .in_rem    (lk_rem[k]),
            .in_quo    (lk_quo[k]),
            .in_div    (lk_div[k]),
            .in_ctrl   (lk_ctrl[k]),
            .out_valid (lk_valid[k+1]),
            .out_ready (lk_ready[k+1]),
            .out_rem   (lk_rem[k+1]),
            .out_quo   (lk_quo[k+1]),
            .out_div   (lk_div[k+1]),
            .out_ctrl  (lk_ctrl[k+1])
         );
      end
   endgenerate

   // Result register. It takes a new result whenever it is empty or its
   // current one is being taken, so the pipeline keeps flowing behind it.
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] target_ff [4];
   logic signed [OUT_W-1:0] target_in [4];
   logic                    fault_ff;
   logic                    out_ready;
   mwm_ctrl_type            last_ctrl;
   logic [Q_W-1:0]          final_mag [4];

   assign last_ctrl = lk_ctrl[STEPS];
   assign out_ready = !rsp_valid_ff || rsp.ready;
   assign lk_ready[STEPS] = out_ready;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         final_mag[i] = last_ctrl.bypass ? lk_rem[STEPS][i][Q_W-1:0] : lk_quo[STEPS][i];
         if (last_ctrl.fault) begin
            target_in[i] = '0;
         end else begin
            target_in[i] = pack_target(last_ctrl.neg[i], PACK_W'(final_mag[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= lk_valid[STEPS];
      end
      if (out_ready && lk_valid[STEPS]) begin
         target_ff <= target_in;
         fault_ff  <= last_ctrl.fault;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.front_left   = target_ff[0];
   assign rsp.front_right  = target_ff[1];
   assign rsp.back_left    = target_ff[2];
   assign rsp.back_right   = target_ff[3];
   assign rsp.layout_fault = fault_ff;

   // A faulted result carries only zero targets.
   a_fault_zero : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.layout_fault |->
         rsp.front_left == '0 && rsp.front_right == '0 &&
         rsp.back_left == '0 && rsp.back_right == '0)
      else $error("faulted result carries non-zero targets");

   // Requests are refused only when every stage is full and the result is stalled.
   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("request refused while the pipeline has room");

   // The cycle after reset no result is offered.
   a_reset_empty : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp.valid)
      else $error("result offered straight after reset");
endmodule
